// ===== hw/rtl/pss_pkg.sv =====
package pss_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 7;
   localparam int ID_W  = 32;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_ERASE  = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   // command broadcast to every cell
   typedef struct packed {
      logic             ins;
      logic             del;
      logic             rd;
      logic [IDX_W-1:0] at;
   } pss_cmd_type;

endpackage

// ===== hw/rtl/pss_cell.sv =====
module pss_cell (
   input  logic                   clock,
   input  pss_pkg::pss_cmd_type   cmd,
   input  logic [pss_pkg::IDX_W-1:0] cell_index,
   input  logic [pss_pkg::ID_W-1:0]  new_id,
   input  logic [pss_pkg::ID_W-1:0]  left_id,
   input  logic [pss_pkg::ID_W-1:0]  right_id,
   output logic [pss_pkg::ID_W-1:0]  id_out,
   output logic [pss_pkg::ID_W-1:0]  rd_out
);
   import pss_pkg::*;

   logic [ID_W-1:0] id_ff, id_in;
   logic [ID_W-1:0] rd_ff, rd_in;

   always_comb begin
      id_in = id_ff;
      if (cmd.ins && (cell_index > cmd.at)) begin
         id_in = left_id;
      end else if (cmd.ins && (cell_index == cmd.at)) begin
         id_in = new_id;
      end else if (cmd.del && (cell_index >= cmd.at)) begin
         id_in = right_id;
      end
   end

   // masked read: only the addressed cell drives nonzero
   assign rd_in = (cmd.rd && (cell_index == cmd.at)) ? id_ff : '0;

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      rd_ff <= rd_in;
   end

   assign id_out = id_ff;
   assign rd_out = rd_ff;

endmodule

// ===== hw/rtl/positional_sequence_store_top.sv =====
// A request's result strobe passes through s1_valid_ff and then rsp_valid_ff;
// insert/erase update the chain at the edge that transfers the request.
// Throughput: one request per cycle; busy is held low, the chain shifts at
// the transfer edge and reads pass through a registered OR bus behind the cells.
// Reset (synchronous, active high) empties the store and drops any result
// in flight; the receiver cannot stall, results are never held.
module positional_sequence_store_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_func,
   input  logic [pss_pkg::POS_W-1:0] req_position,
   input  logic [pss_pkg::ID_W-1:0]  req_new_id,
   output logic                      rsp_valid,
   output logic [pss_pkg::ID_W-1:0]  rsp_read_id,
   output logic                      rsp_error,
   output logic [pss_pkg::POS_W-1:0] rsp_length
);
   import pss_pkg::*;

   logic                 accept;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [POS_W-1:0]     n_ext;
   logic [POS_W-1:0]     at_full;
   logic                 err;
   pss_cmd_type          cmd;

   // stage 1: command done in the chain, read data in cell registers
   logic                 s1_valid_ff;
   logic                 s1_error_ff;
   logic [CNT_W-1:0]     s1_length_ff;

   // result registers
   logic                 rsp_valid_ff;
   logic                 rsp_error_ff;
   logic [CNT_W-1:0]     rsp_length_ff;
   logic [ID_W-1:0]      rsp_read_id_ff, rsp_read_id_in;

   logic [ID_W-1:0]      chain_id [DEPTH];
   logic [ID_W-1:0]      chain_rd [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign n_ext  = POS_W'(count_ff);

   // decode: element position in the chain and the legality checks
   always_comb begin
      cmd      = '0;
      err      = 1'b0;
      count_in = count_ff;
      at_full  = '0;
      case (req_func)
         FUNC_INSERT: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               err = 1'b1;
            end else begin
               // position above count appends at the end
               at_full  = (req_position > n_ext) ? n_ext : req_position;
               cmd.ins  = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         FUNC_ERASE: begin
            if (req_position == '0 || req_position > n_ext) begin
               err = 1'b1;
            end else begin
               at_full  = req_position - POS_W'(1);
               cmd.del  = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         FUNC_READ: begin
            if (req_position == '0 || req_position > n_ext) begin
               err = 1'b1;
            end else begin
               at_full = req_position - POS_W'(1);
               cmd.rd  = accept;
            end
         end
         default: begin
            err = 1'b1;
         end
      endcase
      cmd.at = at_full[IDX_W-1:0];
   end

   // chain of cells: each takes its left neighbor on insert, right on erase
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ID_W-1:0] left_id, right_id;
      if (g == 0) begin : g_first
         assign left_id = '0;
      end else begin : g_mid_l
         assign left_id = chain_id[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_id = '0;
      end else begin : g_mid_r
         assign right_id = chain_id[g+1];
      end
      pss_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(g)),
         .new_id     (req_new_id),
         .left_id    (left_id),
         .right_id   (right_id),
         .id_out     (chain_id[g]),
         .rd_out     (chain_rd[g])
      );
   end

   // OR bus: at most one cell holds a nonzero read word
   always_comb begin
      rsp_read_id_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rsp_read_id_in = rsp_read_id_in | chain_rd[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
      end
      s1_error_ff    <= err;
      s1_length_ff   <= accept ? count_in : count_ff;
      rsp_error_ff   <= s1_error_ff;
      rsp_length_ff  <= s1_length_ff;
      rsp_read_id_ff <= rsp_read_id_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_read_id = rsp_read_id_ff;
   assign rsp_error   = rsp_error_ff;
   assign rsp_length  = POS_W'(rsp_length_ff);

   // every transfer in gives a result strobe, behind the stage-1 and result registers
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("missing result strobe");

   // failed operations never return data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_read_id == '0))
      else $error("read data on error");

   // count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count above depth");

   // count moves only on a transfer
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("count changed without transfer");

endmodule
